// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker. Both sample on the rising edge of clk_i
// and are switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold at the next clock edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/vrd_pkg.sv =====
package vrd_pkg;

  // Interface field widths.
  localparam int CoordW    = 32;
  localparam int AngleW    = 17;
  localparam int InDataW   = 88;  // 81 field bits padded to whole bytes
  localparam int OutDataW  = 64;

  // Iteration count: default and hard cap.
  localparam int IterationsDef = 16;
  localparam int MaxIter       = 32;

  // Datapath: Q16.32 with headroom for the CORDIC growth of a full-scale input.
  localparam int DW = 50;
  // Angle accumulator in 2^-22 degree units.
  localparam int ZW = 31;
  // Reduced angle in 1/128 degree, magnitude at most a quarter turn.
  localparam int RW = 15;
  // Working width of the angle reduction.
  localparam int AW = 18;

  localparam logic signed [AW-1:0] TurnUnits    = 18'sd46080;
  localparam logic signed [AW-1:0] HalfTurn     = 18'sd23040;
  localparam logic signed [AW-1:0] QuarterTurn  = 18'sd11520;

  // Inverse CORDIC gain as Q1.30.
  localparam logic signed [31:0] GainQ30 = 32'sd652032874;

  // atan(2^-i) in 2^-22 degree units, rounded to nearest.
  localparam logic signed [ZW-1:0] AtanTable [MaxIter] = '{
    31'sd188743680, 31'sd111421900, 31'sd58872272, 31'sd29884485,
    31'sd15000234,  31'sd7507429,   31'sd3754631,  31'sd1877430,
    31'sd938729,    31'sd469366,    31'sd234683,   31'sd117342,
    31'sd58671,     31'sd29335,     31'sd14668,    31'sd7334,
    31'sd3667,      31'sd1833,      31'sd917,      31'sd458,
    31'sd229,       31'sd115,       31'sd57,       31'sd29,
    31'sd14,        31'sd7,         31'sd4,        31'sd2,
    31'sd1,         31'sd0,         31'sd0,        31'sd0
  };

  // Vector and residual angle handed from one rotation stage to the next.
  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [ZW-1:0] z;
  } vrd_vec_t;

endpackage

// ===== hdl/vrd_cordic_stage.sv =====
// One CORDIC micro-rotation: shift by STAGE, add or subtract by the sign of the residual angle.
module vrd_cordic_stage #(
  parameter int STAGE = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  vrd_pkg::vrd_vec_t data_i,
  output logic              valid_o,
  output vrd_pkg::vrd_vec_t data_o
);
  import vrd_pkg::*;

  logic                 valid_q;
  vrd_vec_t             data_d, data_q;
  logic signed [DW-1:0] sx, sy;

  assign sx = data_i.x >>> STAGE;
  assign sy = data_i.y >>> STAGE;

  always_comb begin
    if (!data_i.z[ZW-1]) begin
      data_d.x = data_i.x - sy;
      data_d.y = data_i.y + sx;
      data_d.z = data_i.z - AtanTable[STAGE];
    end else begin
      data_d.x = data_i.x + sy;
      data_d.y = data_i.y - sx;
      data_d.z = data_i.z + AtanTable[STAGE];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hdl/vector_rotate_degrees_top.sv =====
// Rotates a Q16.16 point (px, py) counter-clockwise about the origin by angle_deg, given in
// 1/128 degree, and returns the saturated Q16.16 result (rx, ry). Any 17-bit angle is accepted
// and reduced modulo a full turn. One point is accepted per clock cycle while s_axis_tready
// is high. Each result passes through the angle reduction stage, the gain multiply and
// rounding stages, a stage for each CORDIC micro-rotation, the rounding and saturation stage
// and the output register. Iterations beyond 32 are capped at 32. Back-pressure is
// absorbed by a one-entry skid register behind the output register; s_axis_tready drops only
// in the cycle after a result was held back, and rises again as soon as the output drains.
module vector_rotate_degrees_top #(
  parameter int ITERATIONS = vrd_pkg::IterationsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [31:0] px, [63:32] py, [80:64] angle_deg, [87:81] zero.
  input  logic [vrd_pkg::InDataW-1:0]   s_axis_tdata,
  // Output stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [31:0] rx, [63:32] ry.
  output logic [vrd_pkg::OutDataW-1:0]  m_axis_tdata
);
  import vrd_pkg::*;

  // ITERATIONS above the table length gain nothing, so the chain stops at MaxIter stages.
  localparam int NumIter = (ITERATIONS > MaxIter) ? MaxIter : ITERATIONS;

  localparam logic signed [DW-1:0] SatMax = DW'(64'sh7FFF_FFFF);
  localparam logic signed [DW-1:0] SatMin = DW'(-64'sh8000_0000);
  localparam logic signed [DW-1:0] OutRound = DW'(64'sd32768);
  localparam logic signed [63:0]   GainRound = 64'sd8192;

  // Rounds the Q16.32 datapath to Q16.16, half up, and clamps it to 32 bits.
  function automatic logic [CoordW-1:0] vrd_finish(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] t;
    logic [CoordW-1:0]    r;
    t = (v + OutRound) >>> 16;
    if (t > SatMax) begin
      r = SatMax[CoordW-1:0];
    end else if (t < SatMin) begin
      r = SatMin[CoordW-1:0];
    end else begin
      r = t[CoordW-1:0];
    end
    return r;
  endfunction

  // The whole pipeline advances together. It halts only while the skid register is full, and
  // that depends on a register alone, so no ready path runs combinationally through the chain.
  logic en;
  logic skid_valid_q, skid_valid_d;
  assign en            = !skid_valid_q;
  assign s_axis_tready = en;

  // Stage 1: angle reduction and half-turn fold.
  logic signed [CoordW-1:0] in_px, in_py;
  logic signed [AW-1:0]     in_ang, ang_mod, ang_half, ang_fold;
  logic                     do_neg;
  logic signed [CoordW:0]   x1_d, y1_d, x1_q, y1_q;
  logic signed [RW-1:0]     r1_q;
  logic                     v1_q;

  assign in_px  = s_axis_tdata[CoordW-1:0];
  assign in_py  = s_axis_tdata[2*CoordW-1:CoordW];
  assign in_ang = AW'($signed(s_axis_tdata[2*CoordW+AngleW-1:2*CoordW]));

  always_comb begin
    // Truncating remainder by a full turn: the input never reaches two turns in magnitude.
    if (in_ang >= TurnUnits) begin
      ang_mod = in_ang - TurnUnits;
    end else if (in_ang <= -TurnUnits) begin
      ang_mod = in_ang + TurnUnits;
    end else begin
      ang_mod = in_ang;
    end
    // Bring the angle into [-180, 180) degrees.
    if (ang_mod >= HalfTurn) begin
      ang_half = ang_mod - TurnUnits;
    end else if (ang_mod < -HalfTurn) begin
      ang_half = ang_mod + TurnUnits;
    end else begin
      ang_half = ang_mod;
    end
    // Beyond a quarter turn, rotate by half a turn less and negate the vector instead.
    // Exactly plus or minus 90 degrees stays unfolded.
    do_neg = 1'b1;
    if (ang_half > QuarterTurn) begin
      ang_fold = ang_half - HalfTurn;
    end else if (ang_half < -QuarterTurn) begin
      ang_fold = ang_half + HalfTurn;
    end else begin
      ang_fold = ang_half;
      do_neg   = 1'b0;
    end
    x1_d = do_neg ? -(CoordW+1)'(in_px) : (CoordW+1)'(in_px);
    y1_d = do_neg ? -(CoordW+1)'(in_py) : (CoordW+1)'(in_py);
  end

  // Stage 2: gain compensation multiply.
  logic signed [63:0]   px2_q, py2_q;
  logic signed [RW-1:0] r2_q;
  logic                 v2_q;

  // Stage 3: round the products into the Q16.32 datapath and scale the angle.
  logic signed [63:0]   px_rnd, py_rnd;
  vrd_vec_t             vec3_d, vec3_q;
  logic                 v3_q;

  assign px_rnd   = (px2_q + GainRound) >>> 14;
  assign py_rnd   = (py2_q + GainRound) >>> 14;
  assign vec3_d.x = px_rnd[DW-1:0];
  assign vec3_d.y = py_rnd[DW-1:0];
  assign vec3_d.z = {ZW'(r2_q)} <<< 15;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q   <= x1_d;
      y1_q   <= y1_d;
      r1_q   <= ang_fold[RW-1:0];
      px2_q  <= x1_q * GainQ30;
      py2_q  <= y1_q * GainQ30;
      r2_q   <= r1_q;
      vec3_q <= vec3_d;
    end
  end

  // CORDIC micro-rotation chain, one register stage per iteration.
  logic     chain_valid [NumIter+1];
  vrd_vec_t chain_data  [NumIter+1];

  assign chain_valid[0] = v3_q;
  assign chain_data[0]  = vec3_q;

  for (genvar g = 0; g < NumIter; g++) begin : g_iter
    vrd_cordic_stage #(
      .STAGE (g)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_valid[g]),
      .data_i  (chain_data[g]),
      .valid_o (chain_valid[g+1]),
      .data_o  (chain_data[g+1])
    );
  end

  // Final stage: round to Q16.16 and saturate each coordinate on its own.
  logic                sat_valid_q;
  logic [OutDataW-1:0] sat_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_valid_q <= 1'b0;
    end else if (en) begin
      sat_valid_q <= chain_valid[NumIter];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sat_data_q <= {vrd_finish(chain_data[NumIter].y), vrd_finish(chain_data[NumIter].x)};
    end
  end

  // Output register with a skid register behind it. A result leaving the pipeline goes to the
  // output register when that is free or being emptied, and otherwise to the skid register,
  // which is known to be empty whenever the pipeline moves.
  logic                fin_valid;
  logic                out_take;
  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d, skid_data_q, skid_data_d;

  assign fin_valid = sat_valid_q && en;
  assign out_take  = out_valid_q && m_axis_tready;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (out_take || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d  = fin_valid;
        out_data_d   = sat_data_q;
      end
    end else if (fin_valid) begin
      skid_valid_d = 1'b1;
      skid_data_d  = sat_data_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== hdl/vrd_checker.sv =====
`include "assert_macros.svh"

// Watches the ports of the rotation block.
module vrd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [vrd_pkg::OutDataW-1:0] m_axis_tdata
);
  import vrd_pkg::*;

  logic       s_fire, m_fire;
  logic [7:0] pending_q;

  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign m_fire = m_axis_tvalid && m_axis_tready;

  // Transactions accepted whose results have not yet been delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (s_fire && !m_fire) begin
      pending_q <= pending_q + 8'd1;
    end else if (m_fire && !s_fire) begin
      pending_q <= pending_q - 8'd1;
    end
  end

  // A held result keeps its data until it is taken.
  `ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
               m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")

  // Every delivered result belongs to an earlier input transaction.
  `ASSERT_CLK(a_no_invent, !m_fire || (pending_q != 8'd0), "result without a pending input")

  // The input stalls only after the output was held back in the previous cycle.
  `ASSERT_CLK(a_stall_cause, s_axis_tready || $past(m_axis_tvalid && !m_axis_tready),
              "input stalled without output back-pressure")

endmodule

bind vector_rotate_degrees_top vrd_checker u_vrd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/vector_rotate_degrees_top_test.sv =====
// Self-checking bench for the degree-driven CORDIC point rotator. A queue of points is
// filled up front, first with hand-picked corner cases and then with random ones. A clocked
// driver offers them in bursts, a clocked receiver stalls at random, and every output
// transaction is compared with a behavioural rotation computed when its input was accepted.
module vector_rotate_degrees_top_test;

  timeunit 1ns;
  timeprecision 1ps;

  import vrd_pkg::*;

  // Angle bookkeeping in 1/128 degree.
  localparam int FullTurn = 46080;
  localparam int HalfTurnU = 23040;
  localparam int QuarterTurnU = 11520;
  // 1/128 degree units to the 2^-22 degree accumulator.
  localparam longint AngleScale = 32768;
  // Inverse gain, Q1.30.
  localparam longint InvGain = 652032874;
  // Iterations the block under test runs with (default parameter, capped).
  localparam int Steps = (IterationsDef > MaxIter) ? MaxIter : IterationsDef;
  // Input-to-output delay of the pipeline, used for the drain at the end.
  localparam int PipeDelay = IterationsDef + 5;

  localparam logic signed [CoordW-1:0] CoordMax = 32'sh7FFF_FFFF;
  localparam logic signed [CoordW-1:0] CoordMin = 32'sh8000_0000;
  localparam logic signed [CoordW-1:0] One = 32'sh0001_0000;

  typedef struct {
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic signed [AngleW-1:0] ang;
  } point_t;

  typedef struct {
    logic [InDataW-1:0]       src;
    logic signed [CoordW-1:0] rx;
    logic signed [CoordW-1:0] ry;
  } rotation_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  point_t    pending_points[$];
  rotation_t expected_rotations[$];
  int        mismatches = 0;

  // Arctangent of 2^-i in 2^-22 degree units, rounded to nearest.
  longint atan_deg22 [0:31] = '{
    188743680, 111421900, 58872272, 29884485, 15000234, 7507429, 3754631,
    1877430, 938729, 469366, 234683, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0, 0, 0
  };

  vector_rotate_degrees_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Round a Q16.32 value half up to Q16.16 and clamp it to the 32-bit range.
  function automatic logic signed [CoordW-1:0] round_saturate(longint v);
    longint r;
    r = (v + 64'sd32768) >>> 16;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[CoordW-1:0];
  endfunction

  // Expected output of one input transaction: reduce the angle, fold it into a quarter turn
  // either side of zero, apply the gain compensation and run the micro-rotations.
  function automatic rotation_t rotate_point(logic [InDataW-1:0] word);
    rotation_t res;
    longint    x;
    longint    y;
    longint    z;
    longint    sx;
    longint    sy;
    int        r;
    x = longint'($signed(word[31:0]));
    y = longint'($signed(word[63:32]));
    r = int'($signed(word[80:64]));
    r = r % FullTurn;
    if (r >= HalfTurnU) r = r - FullTurn;
    if (r < -HalfTurnU) r = r + FullTurn;
    // A half turn negates the vector; exactly a quarter turn is left alone.
    if (r > QuarterTurnU) begin
      r = r - HalfTurnU;
      x = -x;
      y = -y;
    end else if (r < -QuarterTurnU) begin
      r = r + HalfTurnU;
      x = -x;
      y = -y;
    end
    z = longint'(r) * AngleScale;
    x = (x * InvGain + 64'sd8192) >>> 14;
    y = (y * InvGain + 64'sd8192) >>> 14;
    for (int i = 0; i < Steps; i++) begin
      sx = x >>> i;
      sy = y >>> i;
      if (z >= 0) begin
        x = x - sy;
        y = y + sx;
        z = z - atan_deg22[i];
      end else begin
        x = x + sy;
        y = y - sx;
        z = z + atan_deg22[i];
      end
    end
    res.src = word;
    res.rx = round_saturate(x);
    res.ry = round_saturate(y);
    return res;
  endfunction

  function automatic void add_point(logic signed [CoordW-1:0] px, logic signed [CoordW-1:0] py,
                                    int ang);
    point_t p;
    p.px = px;
    p.py = py;
    p.ang = ang[AngleW-1:0];
    pending_points.push_back(p);
  endfunction

  function automatic logic signed [CoordW-1:0] random_coord();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      // Moderate values, where rounding detail rather than saturation shows.
      return $signed(32'($urandom_range(0, 32'h00FF_FFFF))) - 32'sh0080_0000;
    end else if (pick < 9) begin
      return $signed(32'($urandom));
    end
    case ($urandom_range(0, 4))
      0: return CoordMax;
      1: return CoordMin;
      2: return 32'sd0;
      3: return 32'sd1;
      default: return -32'sd1;
    endcase
  endfunction

  function automatic int random_angle();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick < 4) return int'($urandom_range(0, 2 * FullTurn)) - FullTurn;
    if (pick < 6) return int'($urandom_range(0, 131071)) - 65536;
    // Boundaries of the reduction and of the half-turn fold.
    case ($urandom_range(0, 9))
      0: return 0;
      1: return QuarterTurnU;
      2: return -QuarterTurnU;
      3: return QuarterTurnU + 1;
      4: return -QuarterTurnU - 1;
      5: return HalfTurnU;
      6: return -HalfTurnU;
      7: return HalfTurnU - 1;
      8: return FullTurn;
      default: return -FullTurn;
    endcase
  endfunction

  // Driver: offers queued points in bursts of random length separated by random gaps. The
  // expected rotation is recorded at the edge on which the block accepts the transaction.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    point_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      burst_left    <= 0;
      gap_left      <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        expected_rotations.push_back(rotate_point(s_axis_tdata));
      end
      if (gap_left > 0) begin
        gap_left      <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_points.size() > 0) begin
        nxt = pending_points.pop_front();
        s_axis_tdata  <= {7'd0, nxt.ang, nxt.py, nxt.px};
        s_axis_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          // Roughly half the bursts run straight into the next one.
          gap_left   <= ($urandom_range(0, 9) < 5) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: alternates runs of steady readiness and runs of random stalling. Once, early
  // on, it holds off for a long stretch so that the pipeline and skid register fill and the
  // input side is throttled while the driver keeps offering points.
  int  hold_left = 0;
  int  run_left = 0;
  bit  run_jittery = 1'b0;
  int  results_seen = 0;
  bit  long_hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready  <= 1'b1;
      hold_left      <= 0;
      run_left       <= 0;
      run_jittery    <= 1'b0;
      results_seen   <= 0;
      long_hold_done <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen <= results_seen + 1;
      end
      if (hold_left > 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!long_hold_done && results_seen >= 60) begin
        long_hold_done <= 1'b1;
        hold_left      <= 400;
        m_axis_tready  <= 1'b0;
      end else if (run_left > 0) begin
        run_left      <= run_left - 1;
        m_axis_tready <= run_jittery ? ($urandom_range(0, 2) != 0) : 1'b1;
      end else begin
        run_left      <= $urandom_range(1, 40);
        run_jittery   <= ($urandom_range(0, 2) != 0);
        m_axis_tready <= ($urandom_range(0, 1) != 0);
      end
    end
  end

  // Monitor: every output transaction is checked against the oldest expected rotation.
  always @(posedge clk_i) begin
    rotation_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_rotations.size() == 0) begin
        $display("%0t: unexpected output transaction, data %h", $time, m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_rotations.pop_front();
        if ($signed(m_axis_tdata[31:0]) !== want.rx) begin
          $display("%0t: rx mismatch for input %h: expected %0d, actual %0d", $time,
                   want.src, want.rx, $signed(m_axis_tdata[31:0]));
          mismatches++;
        end
        if ($signed(m_axis_tdata[63:32]) !== want.ry) begin
          $display("%0t: ry mismatch for input %h: expected %0d, actual %0d", $time,
                   want.src, want.ry, $signed(m_axis_tdata[63:32]));
          mismatches++;
        end
      end
    end
  end

  initial begin
    // Directed points: trivial rotations, the quarter and half turns either side, the edges
    // of the reduction, saturating magnitudes and angles beyond a full turn.
    add_point(One, 32'sd0, 0);
    add_point(One, 32'sd0, QuarterTurnU);
    add_point(One, 32'sd0, -QuarterTurnU);
    add_point(One, 32'sh0000_8000, HalfTurnU);
    add_point(One, 32'sh0000_8000, -HalfTurnU);
    add_point(One, 32'sh0002_0000, FullTurn);
    add_point(One, 32'sh0002_0000, -FullTurn);
    add_point(32'sh0003_0000, -One, QuarterTurnU + 1);
    add_point(32'sh0003_0000, -One, -QuarterTurnU - 1);
    add_point(-32'sh0002_0000, 32'sh0001_8000, HalfTurnU - 1);
    add_point(-32'sh0002_0000, 32'sh0001_8000, -HalfTurnU - 1);
    add_point(CoordMax, CoordMax, 5760);
    add_point(CoordMin, CoordMin, 5760);
    add_point(CoordMin, 32'sd0, HalfTurnU);
    add_point(CoordMax, CoordMin, -5760);
    add_point(32'sd0, 32'sd0, 65535);
    add_point(One, One, -65536);
    add_point(-32'sd1, 32'sd1, 12345);
    add_point(32'sh7FFF_0000, 32'sd0, 17000);
    add_point(32'sh5555_5555, 32'shAAAA_AAAA, 32'h0AAAA);
    add_point(32'shAAAA_AAAA, 32'sh5555_5555, 32'h15555 - 131072);
    add_point(-32'sd1, -32'sd1, 0);
    add_point(CoordMax, CoordMax, HalfTurnU);
    add_point(CoordMin, CoordMax, QuarterTurnU);
    repeat (550) add_point(random_coord(), random_coord(), random_angle());

    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_points.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_rotations.size() != 0) @(posedge clk_i);
    repeat (PipeDelay + 10) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: reports the outstanding results and fails the run if it does not finish.
  initial begin
    #1000000;
    $display("%0t: timeout with %0d results outstanding", $time, expected_rotations.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
